// ===== design/assert_macros.svh =====
// Assertion macros shared by the extractor RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// ===== design/jkv_pkg.sv =====
// Types, codes and the result record of the key/value extractor.
// Used by every module of the block; depends on nothing.
`default_nettype none
package jkv_pkg;
	localparam int MAX_KEY_LEN = 32;
	localparam int KEY_BITS = 8 * MAX_KEY_LEN;
	localparam int QDEPTH = 4;
	localparam int QAW = 2;

	typedef enum logic [2:0] {
		PH_SEARCH, PH_AFTER_KEY, PH_VALUE_WS, PH_STRING,
		PH_INT_SIGN, PH_INT_DIGITS, PH_DONE
	} phase_t;

	typedef enum logic [1:0] {ST_OK = 2'd0, ST_NOKEY = 2'd1, ST_FORM = 2'd2} status_t;

	typedef enum logic [1:0] {MODE_STR = 2'd0, MODE_INT = 2'd1, MODE_OBJ = 2'd2} mode_t;

	localparam logic [2:0] REG_MODE = 3'd0;
	localparam logic [2:0] REG_KLEN = 3'd1;
	localparam logic [2:0] REG_KEY0 = 3'd2;
	localparam logic [2:0] REG_KEY1 = 3'd3;
	localparam logic [2:0] REG_KEY2 = 3'd4;
	localparam logic [2:0] REG_KEY3 = 3'd5;
	localparam logic [2:0] REG_CAP = 3'd6;

	typedef struct packed {
		logic        kind;
		logic [1:0]  status;
		logic [7:0]  ch;
		logic [31:0] ival;
		logic [31:0] off;
		logic [15:0] cnt;
		logic        last;
	} res_t;

	// Up to two results per input item.
	typedef struct packed {
		logic [1:0] n;
		res_t r0;
		res_t r1;
	} pair_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic [5:0]  klen;
		logic [KEY_BITS-1:0] key;
		logic [15:0] cap;
	} cfg_t;
endpackage
`default_nettype wire

// ===== design/jkv_cfg.sv =====
// Configuration register bank of the extractor.
// Depends on jkv_pkg.
`default_nettype none
module jkv_cfg (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_we,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [63:0]  cfg_data,
	output jkv_pkg::cfg_t     cfg
);
	jkv_pkg::cfg_t cfg_q;
	assign cfg = cfg_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode <= 2'd0;
			cfg_q.klen <= 6'd1;
			cfg_q.key <= '0;
			cfg_q.cap <= 16'd64;
		end else if (cfg_we) begin
			unique case (cfg_index)
				jkv_pkg::REG_MODE: cfg_q.mode <= cfg_data[1:0];
				jkv_pkg::REG_KLEN: cfg_q.klen <= cfg_data[5:0];
				jkv_pkg::REG_KEY0: cfg_q.key[63:0] <= cfg_data;
				jkv_pkg::REG_KEY1: cfg_q.key[127:64] <= cfg_data;
				jkv_pkg::REG_KEY2: cfg_q.key[191:128] <= cfg_data;
				jkv_pkg::REG_KEY3: cfg_q.key[255:192] <= cfg_data;
				jkv_pkg::REG_CAP: cfg_q.cap <= cfg_data[15:0];
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== design/jkv_front.sv =====
// Front part: accepts bytes, runs the parser state and produces result pairs.
// Depends on jkv_pkg.
`default_nettype none
module jkv_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire jkv_pkg::cfg_t cfg,
	input  wire logic          in_fire,
	input  wire logic          func,
	input  wire logic [7:0]    b,
	output logic               push,
	output jkv_pkg::pair_t     pair
);
	jkv_pkg::phase_t ph_q, ph_d;
	logic [5:0] mi_q, mi_d;
	logic esc_q, esc_d, ovf_q, ovf_d, neg_q, neg_d, dig_q, dig_d;
	logic [15:0] cnt_q, cnt_d;
	logic [31:0] acc_q, acc_d, pos_q;
	logic [5:0] elen;
	logic [7:0] needle;
	logic needle_none;
	logic [15:0] lim, cnt_inc;
	logic [35:0] mac;
	logic [31:0] ires;
	logic [5:0] kidx;
	logic is_dig, is_sp, is_wsp;

	assign elen = (cfg.klen > 6'(jkv_pkg::MAX_KEY_LEN)) ? 6'(jkv_pkg::MAX_KEY_LEN) : cfg.klen;
	assign lim = (cfg.cap != 16'd0) ? cfg.cap - 16'd1 : 16'd0;
	assign cnt_inc = (cnt_q != 16'hFFFF) ? cnt_q + 16'd1 : cnt_q;
	assign kidx = mi_q - 6'd1;
	assign is_dig = (b >= 8'h30) && (b <= 8'h39);
	assign is_sp = (b == 8'h20) || (b == 8'h09);
	assign is_wsp = is_sp || ((b >= 8'd10) && (b <= 8'd13));
	assign mac = {acc_q, 3'b0} + {2'b0, acc_q, 1'b0} + {28'b0, b - 8'h30};
	assign ires = neg_q ? ((acc_q >= 32'h8000_0000) ? 32'h8000_0000 : 32'd0 - acc_q)
		: ((acc_q >= 32'h8000_0000) ? 32'h7FFF_FFFF : acc_q);

	always_comb begin
		needle_none = 1'b0;
		needle = 8'h22;
		if (mi_q == 6'd0 || {1'b0, mi_q} == {1'b0, elen} + 7'd1) needle = 8'h22;
		else if ({1'b0, mi_q} > {1'b0, elen} + 7'd1) needle_none = 1'b1;
		else needle = cfg.key[kidx[4:0]*8 +: 8];
	end

	function automatic jkv_pkg::res_t fin(input logic [1:0] st, input logic [31:0] iv,
		input logic [31:0] of, input logic [15:0] c);
		jkv_pkg::res_t r;
		r.kind = 1'b1; r.status = st; r.ch = 8'd0; r.ival = iv; r.off = of;
		r.cnt = c; r.last = 1'b1;
		return r;
	endfunction

	function automatic jkv_pkg::res_t chr(input logic [7:0] c8, input logic [15:0] c);
		jkv_pkg::res_t r;
		r.kind = 1'b0; r.status = jkv_pkg::ST_OK; r.ch = c8; r.ival = '0; r.off = '0;
		r.cnt = c; r.last = 1'b0;
		return r;
	endfunction

	always_comb begin
		logic [7:0] ch;
		ph_d = ph_q; mi_d = mi_q; esc_d = esc_q; ovf_d = ovf_q; neg_d = neg_q;
		dig_d = dig_q; cnt_d = cnt_q; acc_d = acc_q;
		pair = '0;
		ch = b;
		if (func) begin
			unique case (ph_q)
				jkv_pkg::PH_SEARCH, jkv_pkg::PH_AFTER_KEY: begin
					pair.n = 2'd1; pair.r0 = fin(jkv_pkg::ST_NOKEY, '0, '0, cnt_q);
				end
				jkv_pkg::PH_VALUE_WS, jkv_pkg::PH_INT_SIGN: begin
					pair.n = 2'd1; pair.r0 = fin(jkv_pkg::ST_FORM, '0, '0, cnt_q);
				end
				jkv_pkg::PH_STRING: begin
					if (esc_q) begin
						pair.n = 2'd2; pair.r0 = chr(8'h5C, cnt_inc);
						pair.r1 = fin(jkv_pkg::ST_OK, '0, '0, cnt_inc);
					end else begin
						pair.n = 2'd1; pair.r0 = fin(jkv_pkg::ST_OK, '0, '0, cnt_q);
					end
				end
				jkv_pkg::PH_INT_DIGITS: begin
					pair.n = 2'd1; pair.r0 = fin(jkv_pkg::ST_OK, ires, '0, cnt_q);
				end
				default: ;
			endcase
			ph_d = jkv_pkg::PH_SEARCH; mi_d = '0; esc_d = 1'b0; ovf_d = 1'b0;
			neg_d = 1'b0; dig_d = 1'b0; cnt_d = '0; acc_d = '0;
		end else begin
			unique case (ph_q)
				jkv_pkg::PH_SEARCH, jkv_pkg::PH_AFTER_KEY: begin
					if (ph_q == jkv_pkg::PH_AFTER_KEY && b == 8'h3A) ph_d = jkv_pkg::PH_VALUE_WS;
					else if (ph_q == jkv_pkg::PH_AFTER_KEY && is_sp) ph_d = ph_q;
					else begin
						ph_d = jkv_pkg::PH_SEARCH;
						if (!needle_none && b == needle) begin
							if ({1'b0, mi_q} + 7'd1 >= {1'b0, elen} + 7'd2) begin
								mi_d = '0; ph_d = jkv_pkg::PH_AFTER_KEY;
							end else mi_d = mi_q + 6'd1;
						end else mi_d = (b == 8'h22) ? 6'd1 : 6'd0;
					end
				end
				jkv_pkg::PH_VALUE_WS: begin
					if (!(cfg.mode == jkv_pkg::MODE_INT ? is_wsp : is_sp)) begin
						if (cfg.mode == jkv_pkg::MODE_STR) begin
							esc_d = 1'b0;
							if (b != 8'h22) begin
								pair.n = 2'd1; pair.r0 = fin(jkv_pkg::ST_FORM, '0, '0, cnt_q);
								ph_d = jkv_pkg::PH_DONE;
							end else if (cnt_q >= lim) begin
								pair.n = 2'd1; pair.r0 = fin(jkv_pkg::ST_OK, '0, '0, cnt_q);
								ph_d = jkv_pkg::PH_DONE;
							end else ph_d = jkv_pkg::PH_STRING;
						end else if (cfg.mode == jkv_pkg::MODE_INT) begin
							ovf_d = 1'b0; neg_d = (b == 8'h2D); dig_d = 1'b0; acc_d = '0;
							if (b == 8'h2B || b == 8'h2D) ph_d = jkv_pkg::PH_INT_SIGN;
							else if (is_dig) begin
								acc_d = {24'd0, b - 8'h30}; dig_d = 1'b1;
								ph_d = jkv_pkg::PH_INT_DIGITS;
							end else begin
								pair.n = 2'd1; pair.r0 = fin(jkv_pkg::ST_FORM, '0, '0, cnt_q);
								ph_d = jkv_pkg::PH_DONE;
							end
						end else begin
							pair.n = 2'd1; ph_d = jkv_pkg::PH_DONE;
							if (cfg.mode == jkv_pkg::MODE_OBJ && (b == 8'h7B || b == 8'h5B))
								pair.r0 = fin(jkv_pkg::ST_OK, '0, pos_q, cnt_q);
							else pair.r0 = fin(jkv_pkg::ST_FORM, '0, '0, cnt_q);
						end
					end
				end
				jkv_pkg::PH_STRING: begin
					if (!esc_q && b == 8'h5C) esc_d = 1'b1;
					else if (!esc_q && b == 8'h22) begin
						pair.n = 2'd1; pair.r0 = fin(jkv_pkg::ST_OK, '0, '0, cnt_q);
						ph_d = jkv_pkg::PH_DONE;
					end else begin
						if (esc_q) begin
							esc_d = 1'b0;
							if (b == 8'h6E) ch = 8'd10;
							else if (b == 8'h72) ch = 8'd13;
							else if (b == 8'h74) ch = 8'd9;
						end
						cnt_d = cnt_inc;
						pair.r0 = chr(ch, cnt_inc);
						if (cnt_inc >= lim) begin
							pair.n = 2'd2; pair.r1 = fin(jkv_pkg::ST_OK, '0, '0, cnt_inc);
							ph_d = jkv_pkg::PH_DONE;
						end else pair.n = 2'd1;
					end
				end
				jkv_pkg::PH_INT_SIGN, jkv_pkg::PH_INT_DIGITS: begin
					if (is_dig) begin
						if (mac > 36'h8000_0000) begin
							acc_d = 32'h8000_0000; ovf_d = 1'b1;
						end else acc_d = mac[31:0];
						dig_d = 1'b1; ph_d = jkv_pkg::PH_INT_DIGITS;
					end else begin
						pair.n = 2'd1; ph_d = jkv_pkg::PH_DONE;
						pair.r0 = (ph_q == jkv_pkg::PH_INT_SIGN)
							? fin(jkv_pkg::ST_FORM, '0, '0, cnt_q)
							: fin(jkv_pkg::ST_OK, ires, '0, cnt_q);
					end
				end
				default: ;
			endcase
		end
	end

	assign push = in_fire && (pair.n != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= jkv_pkg::PH_SEARCH; mi_q <= '0; esc_q <= 1'b0; ovf_q <= 1'b0;
			neg_q <= 1'b0; dig_q <= 1'b0; cnt_q <= '0; acc_q <= '0; pos_q <= '0;
		end else if (in_fire) begin
			ph_q <= ph_d; mi_q <= mi_d; esc_q <= esc_d; ovf_q <= ovf_d;
			neg_q <= neg_d; dig_q <= dig_d; cnt_q <= cnt_d; acc_q <= acc_d;
			if (func) pos_q <= '0;
			else if (pos_q != 32'hFFFF_FFFF) pos_q <= pos_q + 32'd1;
		end
	end
endmodule
`default_nettype wire

// ===== design/jkv_back.sv =====
// Back part: a short queue of result pairs and the output selector that
// sends them one result per request. Depends on jkv_pkg.
`default_nettype none
module jkv_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire jkv_pkg::pair_t pair,
	output logic                room,
	output logic                ovalid,
	input  wire logic           oready,
	output jkv_pkg::res_t       ores,
	output logic [2:0]          level
);
	jkv_pkg::pair_t mem [jkv_pkg::QDEPTH];
	logic [jkv_pkg::QAW-1:0] wp_q, rp_q;
	logic [jkv_pkg::QAW:0] cnt_q;
	logic sel_q, pop;
	jkv_pkg::pair_t head;

	assign head = mem[rp_q];
	assign room = cnt_q < 3'(jkv_pkg::QDEPTH - 1);
	assign level = cnt_q;
	assign ovalid = cnt_q != '0;
	assign ores = sel_q ? head.r1 : head.r0;
	assign pop = ovalid && oready && (sel_q || head.n == 2'd1);

	always_ff @(posedge clk) begin
		if (push) mem[wp_q] <= pair;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0; sel_q <= 1'b0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (push ? 3'd1 : 3'd0) - (pop ? 3'd1 : 3'd0);
			if (ovalid && oready) sel_q <= !pop;
		end
	end
endmodule
`default_nettype wire

// ===== design/json_key_value_extractor.sv =====
// Channel   | Dir | Fields (low bit first)
// s_axis    | in  | tdata: text_byte[7:0]; tuser: func
// m_axis    | out | tdata: status, out_char, int_value, value_offset, char_count;
//           |     | tuser: result_kind; tlast: last
// cfg       | in  | cfg_we, cfg_index, cfg_data (64 bits)
// One input byte per cycle while the queue has room; parser state is registered per byte.
// Results pass a four-entry pair queue; one leaves per cycle while m_axis_tready is high.
// Input stalls when the queue holds three pairs. Asynchronous reset, no clearing pass.
// Top level of the extractor; depends on jkv_pkg, jkv_cfg, jkv_front, jkv_back.
`default_nettype none
`include "assert_macros.svh"
module json_key_value_extractor (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [63:0] cfg_data,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,  // text_byte
	input  wire logic        s_axis_tuser,  // func
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// status[1:0], out_char[9:2], int_value[41:10], value_offset[73:42], char_count[89:74]
	output logic [95:0]      m_axis_tdata,
	output logic             m_axis_tuser,  // result_kind
	output logic             m_axis_tlast
);
	jkv_pkg::cfg_t cfg;
	jkv_pkg::pair_t pair;
	jkv_pkg::res_t ores;
	logic push, room, fire;
	logic [2:0] level;

	assign s_axis_tready = room;
	assign fire = s_axis_tvalid && s_axis_tready;

	jkv_cfg u_cfg (.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data, .cfg);
	jkv_front u_front (.clk, .arst_n, .cfg, .in_fire(fire), .func(s_axis_tuser),
		.b(s_axis_tdata), .push, .pair);
	jkv_back u_back (.clk, .arst_n, .push, .pair, .room, .ovalid(m_axis_tvalid),
		.oready(m_axis_tready), .ores, .level);

	assign m_axis_tdata = {6'd0, ores.cnt, ores.off, ores.ival, ores.ch, ores.status};
	assign m_axis_tuser = ores.kind;
	assign m_axis_tlast = ores.last;

	`ASSERT_IMPL(a_no_overflow, clk, arst_n, push, level < 3'd4)
	`ASSERT_IMPL(a_last_kind, clk, arst_n, m_axis_tvalid, m_axis_tlast == m_axis_tuser)
	`ASSERT_NEXT(a_push_level, clk, arst_n, push && !m_axis_tvalid, level != 3'd0)
endmodule
`default_nettype wire
